// ----- rtl/core/wbc_pkg.sv -----
// Shared types, constants and the arctangent table for the waypoint bearing block.
// No dependencies; every other file in rtl/core imports this package.
package wbc_pkg;

    localparam int COORD_BITS          = 24;
    localparam int ANGLE_ITERATIONS_DEF = 20;
    localparam int DIST_BITS           = COORD_BITS + 1;
    localparam int RADIUS_BITS         = 24;

    localparam logic [1:0] FUNC_GOAL    = 2'd0;
    localparam logic [1:0] FUNC_POSITION = 2'd1;
    localparam logic [1:0] FUNC_HEADING = 2'd2;
    localparam logic [1:0] FUNC_TICK    = 2'd3;

    localparam logic [1:0] KIND_PROXIMITY = 2'd0;
    localparam logic [1:0] KIND_PARKING   = 2'd1;

    localparam logic [1:0] REG_CAPTURE     = 2'd0;
    localparam logic [1:0] REG_SLIP        = 2'd1;
    localparam logic [1:0] REG_PASSTHROUGH = 2'd2;

    localparam logic [RADIUS_BITS-1:0] CAPTURE_RESET = 24'd1000;
    localparam logic [RADIUS_BITS-1:0] SLIP_RESET    = 24'd200;

    typedef struct packed {
        logic [1:0]                   func;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic [15:0]                  goal_number;
        logic signed [15:0]           goal_depth;
        logic [1:0]                   goal_kind;
        logic                         depth_reference;
        logic signed [15:0]           goal_speed;
        logic signed [15:0]           heading_fix;
        logic [31:0]                  timestamp;
    } in_item_t;

    typedef struct packed {
        logic [15:0]          waypoint_number;
        logic [DIST_BITS-1:0] distance;
        logic                 achieved;
        logic [31:0]          dwell_report;
        logic signed [15:0]   steer_heading;
        logic signed [15:0]   steer_depth;
        logic signed [15:0]   steer_speed;
        logic                 desired_from_bottom;
    } out_item_t;

    // Binary-angle arctangent of 2^-i, one turn = 2^32.
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/wbc_magnitude.sv -----
// Bit-serial square-and-sum followed by a two-bits-per-cycle integer square root.
// Depends on wbc_pkg.
module wbc_magnitude
    import wbc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [COORD_BITS:0]   dx,
    input  logic signed [COORD_BITS:0]   dy,
    output logic                         done,
    output logic [DIST_BITS-1:0]         root
);
    localparam int C    = COORD_BITS;
    localparam int RW   = DIST_BITS;
    localparam int PW   = 2 * RW;
    localparam int REMW = RW + 3;
    localparam int CW   = $clog2(C + 1);

    typedef enum logic [1:0] {M_IDLE, M_SQX, M_SQY, M_ROOT} mag_state_t;

    mag_state_t       state_reg;
    logic [2*C-1:0]   mcand_reg;
    logic [C-1:0]     mplier_reg;
    logic [C-1:0]     ay_reg;
    logic [PW-1:0]    acc_reg;
    logic [REMW-1:0]  rem_reg;
    logic [RW-1:0]    root_reg;
    logic [CW-1:0]    cnt_reg;
    logic             done_reg;

    logic [C-1:0]     ax;
    logic [C-1:0]     ay;
    logic [PW-1:0]    acc_next;
    logic [REMW-1:0]  rem_sh;
    logic [REMW-1:0]  trial;

    assign ax = dx[C] ? C'(-dx) : dx[C-1:0];
    assign ay = dy[C] ? C'(-dy) : dy[C-1:0];
    assign acc_next = acc_reg + (mplier_reg[0] ? PW'(mcand_reg) : '0);
    assign rem_sh = {rem_reg[REMW-3:0], acc_reg[PW-1:PW-2]};
    assign trial  = REMW'({root_reg, 2'b01});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= M_IDLE;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
            mcand_reg  <= '0;
            mplier_reg <= '0;
            ay_reg     <= '0;
            acc_reg    <= '0;
            rem_reg    <= '0;
            root_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        mcand_reg  <= (2*C)'(ax);
                        mplier_reg <= ax;
                        ay_reg     <= ay;
                        acc_reg    <= '0;
                        cnt_reg    <= '0;
                        state_reg  <= M_SQX;
                    end
                end
                M_SQX:
                begin
                    acc_reg    <= acc_next;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(C - 1))
                    begin
                        mcand_reg  <= (2*C)'(ay_reg);
                        mplier_reg <= ay_reg;
                        cnt_reg    <= '0;
                        state_reg  <= M_SQY;
                    end
                end
                M_SQY:
                begin
                    acc_reg    <= acc_next;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(C - 1))
                    begin
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= M_ROOT;
                    end
                end
                M_ROOT:
                begin
                    acc_reg <= acc_reg << 2;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (rem_sh >= trial)
                    begin
                        rem_reg  <= rem_sh - trial;
                        root_reg <= {root_reg[RW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[RW-2:0], 1'b0};
                    end
                    if (cnt_reg == CW'(RW - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= M_IDLE;
                    end
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- rtl/core/wbc_bearing.sv -----
// Iterative vectoring unit: bearing of (dx, dy) in rounded centidegrees.
// Depends on wbc_pkg (atan_entry, COORD_BITS).
module wbc_bearing
    import wbc_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [COORD_BITS:0] dx,
    input  logic signed [COORD_BITS:0] dy,
    output logic                       done,
    output logic signed [15:0]         heading
);
    localparam int C  = COORD_BITS;
    localparam int XW = C + 9;
    localparam int IW = $clog2(ANGLE_ITERATIONS);

    typedef enum logic [1:0] {B_IDLE, B_ITER, B_MUL, B_FIN} brg_state_t;

    brg_state_t          state_reg;
    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] y_reg;
    logic [31:0]         z_reg;
    logic [IW-1:0]       cnt_reg;
    logic [47:0]         prod_reg;
    logic                done_reg;
    logic signed [15:0]  heading_reg;

    logic signed [XW-1:0] x0;
    logic signed [XW-1:0] y0;
    logic signed [XW-1:0] sx;
    logic signed [XW-1:0] sy;
    logic [31:0]         step;
    logic [31:0]         u;
    logic [47:0]         rounded;
    logic [15:0]         cd;
    logic [15:0]         cd_wrap;

    assign x0 = {{(XW-C-7){dx[C]}}, dx, 6'b0};
    assign y0 = {{(XW-C-7){dy[C]}}, dy, 6'b0};
    assign sx = x_reg >>> cnt_reg;
    assign sy = y_reg >>> cnt_reg;
    assign step = atan_entry(5'(cnt_reg));
    assign u = z_reg + 32'h8000_0000;
    assign rounded = prod_reg + 48'h8000_0000;
    assign cd = rounded[47:32];
    assign cd_wrap = (cd >= 16'd36000) ? cd - 16'd36000 : cd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            done_reg    <= 1'b0;
            x_reg       <= '0;
            y_reg       <= '0;
            z_reg       <= '0;
            cnt_reg     <= '0;
            prod_reg    <= '0;
            heading_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                B_IDLE:
                begin
                    if (start)
                    begin
                        cnt_reg <= '0;
                        if (dx[C])
                        begin
                            x_reg <= -x0;
                            y_reg <= -y0;
                            z_reg <= 32'h8000_0000;
                        end
                        else
                        begin
                            x_reg <= x0;
                            y_reg <= y0;
                            z_reg <= '0;
                        end
                        state_reg <= B_ITER;
                    end
                end
                B_ITER:
                begin
                    if (!y_reg[XW-1])
                    begin
                        x_reg <= x_reg + sy;
                        y_reg <= y_reg - sx;
                        z_reg <= z_reg + step;
                    end
                    else
                    begin
                        x_reg <= x_reg - sy;
                        y_reg <= y_reg + sx;
                        z_reg <= z_reg - step;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == IW'(ANGLE_ITERATIONS - 1))
                    begin
                        state_reg <= B_MUL;
                    end
                end
                B_MUL:
                begin
                    prod_reg  <= 48'(u) * 48'd36000;
                    state_reg <= B_FIN;
                end
                B_FIN:
                begin
                    heading_reg <= cd_wrap - 16'd18000;
                    done_reg    <= 1'b1;
                    state_reg   <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    assign done    = done_reg;
    assign heading = heading_reg;

endmodule

// ----- rtl/core/waypoint_bearing_and_capture_top.sv -----
// Top level of the waypoint bearing and capture block: event decode, state, dwell, output.
// Depends on wbc_pkg, wbc_magnitude and wbc_bearing.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  in       | in_valid / in_ready    | in_data  (in_item_t): one event
//  out      | out_valid / out_ready  | out_data (out_item_t): one guidance report
//  apb      | psel/penable/pready    | paddr, pwdata, prdata: three registers
//
// Goal, position and heading events only update the held state. A tick with goal and
// position held starts both units; the serial square-and-sum plus root in wbc_magnitude
// sets the pace, and the vectoring unit runs beside it. No event is taken until the
// report is committed. A tick without goal or position gives no report.
// Reset is asynchronous, active low, and clears all but the radii; no report is pending.
// The output register holds a report until taken; a finished tick waits for it to empty.
module waypoint_bearing_and_capture_top
    import wbc_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int C = COORD_BITS;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_EMIT} top_state_t;

    // Configuration registers
    logic [RADIUS_BITS-1:0] capture_reg;
    logic [RADIUS_BITS-1:0] slip_reg;
    logic                   passthrough_reg;

    // Guidance state
    top_state_t             state_reg;
    logic                   goal_valid_reg;
    logic                   pos_valid_reg;
    logic                   hdg_valid_reg;
    logic [15:0]            target_id_reg;
    logic signed [C-1:0]    target_east_reg;
    logic signed [C-1:0]    target_north_reg;
    logic signed [15:0]     target_depth_reg;
    logic [1:0]             target_kind_reg;
    logic                   target_bottom_reg;
    logic signed [15:0]     target_speed_reg;
    logic signed [C-1:0]    own_east_reg;
    logic signed [C-1:0]    own_north_reg;
    logic [31:0]            dwell_reg;
    logic                   inside_reg;
    logic [31:0]            last_check_reg;
    logic [31:0]            tick_ts_reg;
    logic                   mag_ok_reg;
    logic                   brg_ok_reg;
    logic                   out_valid_reg;
    out_item_t              out_reg;

    logic                   in_fire;
    logic                   out_free;
    logic                   cfg_write;
    logic                   start;
    logic signed [C:0]      dx;
    logic signed [C:0]      dy;
    logic                   mag_done;
    logic [DIST_BITS-1:0]   goal_range;
    logic                   brg_done;
    logic signed [15:0]     bearing;
    logic [31:0]            dt;
    logic [32:0]            dwell_sum;
    logic [31:0]            dwell_next;
    logic                   inside_next;
    logic                   in_capture;
    logic [31:0]            report;
    logic                   achieved;
    logic                   new_goal;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    // Offsets; one extra bit keeps the difference of two coordinates exact
    assign dx = {target_east_reg[C-1], target_east_reg} - {own_east_reg[C-1], own_east_reg};
    assign dy = {target_north_reg[C-1], target_north_reg}
              - {own_north_reg[C-1], own_north_reg};

    assign start = in_fire && (in_data.func == FUNC_TICK) && goal_valid_reg && pos_valid_reg;

    wbc_magnitude u_magnitude
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .dx    (dx),
        .dy    (dy),
        .done  (mag_done),
        .root  (goal_range)
    );

    wbc_bearing #(
        .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
    ) u_bearing
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .dx      (dx),
        .dy      (dy),
        .done    (brg_done),
        .heading (bearing)
    );

    // Dwell bookkeeping for parking goals: elapsed time wraps, the sum saturates
    assign dt         = tick_ts_reg - last_check_reg;
    assign dwell_sum  = {1'b0, dwell_reg} + {1'b0, dt};
    assign in_capture = goal_range < DIST_BITS'(capture_reg);

    always_comb
    begin
        dwell_next  = dwell_reg;
        inside_next = inside_reg;
        report      = '0;
        achieved    = 1'b0;
        case (target_kind_reg)
            KIND_PROXIMITY:
            begin
                achieved = goal_range < DIST_BITS'(slip_reg);
            end
            KIND_PARKING:
            begin
                if (in_capture)
                begin
                    dwell_next  = dwell_sum[32] ? 32'hFFFF_FFFF : dwell_sum[31:0];
                    inside_next = 1'b1;
                end
                else if (inside_reg)
                begin
                    dwell_next  = '0;
                    inside_next = 1'b0;
                end
                report   = dwell_next;
                achieved = inside_next;
            end
            default:
            begin
                achieved = 1'b0;
            end
        endcase
    end

    assign new_goal = !goal_valid_reg || (in_data.goal_number != target_id_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capture_reg       <= CAPTURE_RESET;
            slip_reg          <= SLIP_RESET;
            passthrough_reg   <= 1'b0;
            state_reg         <= S_IDLE;
            goal_valid_reg    <= 1'b0;
            pos_valid_reg     <= 1'b0;
            hdg_valid_reg     <= 1'b0;
            target_id_reg     <= '0;
            target_east_reg   <= '0;
            target_north_reg  <= '0;
            target_depth_reg  <= '0;
            target_kind_reg   <= '0;
            target_bottom_reg <= 1'b0;
            target_speed_reg  <= '0;
            own_east_reg      <= '0;
            own_north_reg     <= '0;
            dwell_reg         <= '0;
            inside_reg        <= 1'b0;
            last_check_reg    <= '0;
            tick_ts_reg       <= '0;
            mag_ok_reg        <= 1'b0;
            brg_ok_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
            out_reg           <= '0;
        end
        else
        begin
            // Register writes; unknown addresses drop silently
            if (cfg_write)
            begin
                case (paddr[3:2])
                    REG_CAPTURE:     capture_reg     <= pwdata[RADIUS_BITS-1:0];
                    REG_SLIP:        slip_reg        <= pwdata[RADIUS_BITS-1:0];
                    REG_PASSTHROUGH: passthrough_reg <= pwdata[0];
                    default:         ;
                endcase
            end

            // Raise valid on a commit, otherwise drop it once the report is taken
            if ((state_reg == S_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        case (in_data.func)
                            FUNC_GOAL:
                            begin
                                if (new_goal)
                                begin
                                    dwell_reg      <= '0;
                                    inside_reg     <= 1'b0;
                                    last_check_reg <= in_data.timestamp;
                                end
                                target_id_reg     <= in_data.goal_number;
                                target_east_reg   <= in_data.coord_x;
                                target_north_reg  <= in_data.coord_y;
                                target_depth_reg  <= in_data.goal_depth;
                                target_kind_reg   <= in_data.goal_kind;
                                target_bottom_reg <= in_data.depth_reference;
                                target_speed_reg  <= in_data.goal_speed;
                                goal_valid_reg    <= 1'b1;
                            end
                            FUNC_POSITION:
                            begin
                                own_east_reg  <= in_data.coord_x;
                                own_north_reg <= in_data.coord_y;
                                pos_valid_reg <= 1'b1;
                            end
                            FUNC_HEADING:
                            begin
                                // Heading value is not kept: once held, the bearing replaces it
                                hdg_valid_reg <= 1'b1;
                            end
                            default:
                            begin
                                if (start)
                                begin
                                    tick_ts_reg <= in_data.timestamp;
                                    mag_ok_reg  <= 1'b0;
                                    brg_ok_reg  <= 1'b0;
                                    state_reg   <= S_RUN;
                                end
                            end
                        endcase
                    end
                end
                S_RUN:
                begin
                    // Collect both units' done pulses
                    if (mag_done)
                    begin
                        mag_ok_reg <= 1'b1;
                    end
                    if (brg_done)
                    begin
                        brg_ok_reg <= 1'b1;
                    end
                    if ((mag_ok_reg || mag_done) && (brg_ok_reg || brg_done))
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    // Hold until the output register is free, then commit
                    if (out_free)
                    begin
                        if (target_kind_reg == KIND_PARKING)
                        begin
                            last_check_reg <= tick_ts_reg;
                        end
                        dwell_reg                   <= dwell_next;
                        inside_reg                  <= inside_next;
                        out_reg.waypoint_number     <= target_id_reg;
                        out_reg.distance            <= goal_range;
                        out_reg.achieved            <= achieved;
                        out_reg.dwell_report        <= report;
                        out_reg.steer_heading       <= hdg_valid_reg ? bearing : 16'sd0;
                        out_reg.steer_depth         <= passthrough_reg ? 16'sd0
                                                                       : target_depth_reg;
                        out_reg.steer_speed         <= passthrough_reg ? 16'sd0
                                                                       : target_speed_reg;
                        out_reg.desired_from_bottom <= !passthrough_reg && target_bottom_reg;
                        state_reg                   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_CAPTURE:     prdata = 32'(capture_reg);
            REG_SLIP:        prdata = 32'(slip_reg);
            REG_PASSTHROUGH: prdata = 32'(passthrough_reg);
            default:         prdata = '0;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A report appears only out of the commit state
    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("report raised outside commit");

    // A tick with goal and position held starts the computation
    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (state_reg == S_RUN))
        else $error("tick did not start computation");

    // Accumulated dwell only exists while inside the capture radius
    a_dwell_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (dwell_reg != 32'd0) |-> inside_reg)
        else $error("dwell held outside capture radius");

endmodule

// ----- sim/tb_waypoint_bearing_and_capture_top.sv -----
// Testbench for waypoint_bearing_and_capture_top: random and directed events,
// APB register phases, a bit-exact guidance predictor and an in-order scoreboard.
// Depends on wbc_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module tb_waypoint_bearing_and_capture_top
    import wbc_pkg::*;
();

    // Hold the expected guidance reports and compare each delivered report with the oldest.
    class guidance_scoreboard;
        out_item_t pending_reports[$];
        int        mismatches;
        int        reports_checked;

        function void note_report(out_item_t r);
            pending_reports.push_back(r);
        endfunction

        task flag(string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        task check_report(out_item_t got);
            out_item_t want;
            if (pending_reports.size() == 0)
            begin
                flag($sformatf("unexpected report %p", got));
                return;
            end
            want = pending_reports.pop_front();
            reports_checked++;
            if (got.waypoint_number !== want.waypoint_number)
                flag($sformatf("waypoint_number %0d want %0d", got.waypoint_number,
                    want.waypoint_number));
            if (got.distance !== want.distance)
                flag($sformatf("distance %0d want %0d", got.distance, want.distance));
            if (got.achieved !== want.achieved)
                flag($sformatf("achieved %0b want %0b", got.achieved, want.achieved));
            if (got.dwell_report !== want.dwell_report)
                flag($sformatf("dwell_report %0d want %0d", got.dwell_report,
                    want.dwell_report));
            if (got.steer_heading !== want.steer_heading)
                flag($sformatf("steer_heading %0d want %0d", got.steer_heading,
                    want.steer_heading));
            if (got.steer_depth !== want.steer_depth)
                flag($sformatf("steer_depth %0d want %0d", got.steer_depth,
                    want.steer_depth));
            if (got.steer_speed !== want.steer_speed)
                flag($sformatf("steer_speed %0d want %0d", got.steer_speed,
                    want.steer_speed));
            if (got.desired_from_bottom !== want.desired_from_bottom)
                flag($sformatf("desired_from_bottom %0b want %0b", got.desired_from_bottom,
                    want.desired_from_bottom));
        endtask
    endclass

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 200;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    waypoint_bearing_and_capture_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    guidance_scoreboard board;

    // Idle percentages for the sender and the receiver, changed per phase.
    int send_idle_pct;
    int recv_stall_pct;
    int cycle_count = 0;
    int events_sent;
    int ticks_parking;

    // Predictor copy of the block's registers and state.
    logic [23:0]        cap_radius_q;
    logic [23:0]        slip_radius_q;
    logic               passthru_q;
    logic               have_goal, have_pos, have_hdg;
    logic [15:0]        tgt_id;
    logic signed [23:0] tgt_e, tgt_n, own_e, own_n;
    logic signed [15:0] tgt_depth, tgt_speed, own_hdg;
    logic [1:0]         tgt_kind;
    logic               tgt_bottom;
    logic [31:0]        dwell_ms;
    logic               in_capture;
    logic [31:0]        last_parking_ts;

    // Binary-angle arctangent of 2^-i, one turn = 2^32.
    logic [31:0] atan_turns [0:31] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Vectoring rotation: bearing of (dx, dy) in centidegrees, rounded half up.
    function automatic logic signed [15:0] bearing_cdeg(longint dx, longint dy);
        longint      x, y, nx;
        logic [31:0] z;
        logic [63:0] u, cd;
        x = dx * 64;
        y = dy * 64;
        z = 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < 20; i++)
        begin
            // >>> on longint floors toward minus infinity
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + atan_turns[i];
            end
            else
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - atan_turns[i];
            end
            x = nx;
        end
        u = {32'd0, z + 32'h8000_0000};
        cd = (u * 64'd36000 + 64'h8000_0000) >> 32;
        if (cd >= 36000)
            cd = cd - 36000;
        return 16'(int'(cd) - 18000);
    endfunction

    // Advance the predictor by one accepted event; queue the report a tick produces.
    task automatic predict_event(in_item_t ev);
        longint      dx, dy;
        logic [63:0] range_cm;
        logic [31:0] dt;
        out_item_t   r;
        case (ev.func)
            FUNC_GOAL:
            begin
                if (!have_goal || ev.goal_number != tgt_id)
                begin
                    dwell_ms = 0;
                    in_capture = 0;
                    last_parking_ts = ev.timestamp;
                end
                tgt_id = ev.goal_number;
                tgt_e = ev.coord_x;
                tgt_n = ev.coord_y;
                tgt_depth = ev.goal_depth;
                tgt_kind = ev.goal_kind;
                tgt_bottom = ev.depth_reference;
                tgt_speed = ev.goal_speed;
                have_goal = 1;
            end
            FUNC_POSITION:
            begin
                own_e = ev.coord_x;
                own_n = ev.coord_y;
                have_pos = 1;
            end
            FUNC_HEADING:
            begin
                own_hdg = ev.heading_fix;
                have_hdg = 1;
            end
            default:
            begin
                if (have_goal && have_pos)
                begin
                    dx = longint'(tgt_e) - longint'(own_e);
                    dy = longint'(tgt_n) - longint'(own_n);
                    range_cm = int_sqrt(64'(dx * dx) + 64'(dy * dy));
                    r = '0;
                    r.waypoint_number = tgt_id;
                    r.distance = range_cm[DIST_BITS-1:0];
                    r.steer_heading = have_hdg ? bearing_cdeg(dx, dy) : own_hdg;
                    if (tgt_kind == KIND_PROXIMITY)
                        r.achieved = range_cm < {40'd0, slip_radius_q};
                    else if (tgt_kind == KIND_PARKING)
                    begin
                        ticks_parking++;
                        dt = ev.timestamp - last_parking_ts;
                        last_parking_ts = ev.timestamp;
                        if (range_cm < {40'd0, cap_radius_q})
                        begin
                            // saturate instead of wrapping
                            dwell_ms = (dwell_ms > 32'hFFFF_FFFF - dt) ? 32'hFFFF_FFFF
                                                                      : dwell_ms + dt;
                            in_capture = 1;
                        end
                        else if (in_capture)
                        begin
                            dwell_ms = 0;
                            in_capture = 0;
                        end
                        r.dwell_report = dwell_ms;
                        r.achieved = in_capture;
                    end
                    if (!passthru_q)
                    begin
                        r.steer_depth = tgt_depth;
                        r.steer_speed = tgt_speed;
                        r.desired_from_bottom = tgt_bottom;
                    end
                    board.note_report(r);
                end
            end
        endcase
    endtask

    // Offer one event, honoring the sender idle rate, and hold it until accepted.
    task automatic send_event(in_item_t ev);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= ev;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_event(ev);
        events_sent++;
    endtask

    // Write one register through the APB setup and access phases.
    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_CAPTURE:     cap_radius_q = value[23:0];
            REG_SLIP:        slip_radius_q = value[23:0];
            REG_PASSTHROUGH: passthru_q = value[0];
            default:         ;
        endcase
    endtask

    // Drop valid, wait until the block has delivered every queued report, then settle.
    task automatic drain_reports();
        in_valid <= 1'b0;
        while (board.pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [23:0] rand_coord(logic signed [23:0] center);
        case ($urandom_range(5))
            0: return 24'($urandom);
            1: return $urandom_range(1) ? 24'sh7F_FFFF : 24'sh80_0000;
            2: return center + 24'($signed(int'($urandom_range(400))) - 200);
            default: return center + 24'($signed(int'($urandom_range(4000))) - 2000);
        endcase
    endfunction

    // Build one random event. Ticks dominate; goal ids mostly repeat to build dwell.
    function automatic in_item_t rand_event(ref logic [31:0] clock_ms);
        in_item_t ev;
        int sel;
        ev = in_item_t'(($bits(in_item_t))'({$urandom, $urandom, $urandom, $urandom,
                                             $urandom}));
        sel = $urandom_range(99);
        ev.func = sel < 10 ? FUNC_GOAL : sel < 35 ? FUNC_POSITION
                : sel < 45 ? FUNC_HEADING : FUNC_TICK;
        if (ev.func == FUNC_GOAL)
        begin
            ev.goal_number = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(3));
            ev.goal_kind = $urandom_range(9) < 4 ? KIND_PARKING : 2'($urandom_range(3));
            ev.coord_x = rand_coord(24'sd0);
            ev.coord_y = rand_coord(24'sd0);
        end
        else if (ev.func == FUNC_POSITION)
        begin
            ev.coord_x = rand_coord(tgt_e);
            ev.coord_y = rand_coord(tgt_n);
        end
        ev.heading_fix = 16'($signed(int'($urandom_range(35999))) - 18000);
        if ($urandom_range(19) != 0)
        begin
            clock_ms = clock_ms + $urandom_range(200);
            ev.timestamp = clock_ms;
        end
        return ev;
    endfunction

    function automatic in_item_t make_event(logic [1:0] f, logic signed [23:0] x,
                                            logic signed [23:0] y, logic [15:0] id,
                                            logic [1:0] kind, logic [31:0] ts);
        in_item_t ev;
        ev = '0;
        ev.func = f;
        ev.coord_x = x;
        ev.coord_y = y;
        ev.goal_number = id;
        ev.goal_kind = kind;
        ev.goal_depth = 16'sh7FFF;
        ev.goal_speed = 16'sh8000;
        ev.depth_reference = 1'b1;
        ev.timestamp = ts;
        return ev;
    endfunction

    // Drain the output channel, stalling at the receiver rate, and check each report.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_report(out_data);
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] clock_ms;
        in_item_t    ev;
        board = new();
        events_sent = 0;
        ticks_parking = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cap_radius_q = CAPTURE_RESET;
        slip_radius_q = SLIP_RESET;
        passthru_q = 1'b0;
        have_goal = 0; have_pos = 0; have_hdg = 0;
        tgt_id = 0; tgt_e = 0; tgt_n = 0; own_e = 0; own_n = 0;
        tgt_depth = 0; tgt_speed = 0; own_hdg = 0; tgt_kind = 0; tgt_bottom = 0;
        dwell_ms = 0; in_capture = 0; last_parking_ts = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: tick before anything is held, reset heading, zero offset,
        // extreme coordinates, dwell saturation, timestamp wrap, leaving the radius.
        send_event(make_event(FUNC_TICK, 0, 0, 0, 0, 0));
        send_event(make_event(FUNC_GOAL, 0, 0, 16'hFFFF, KIND_PROXIMITY, 32'd5));
        send_event(make_event(FUNC_TICK, 0, 0, 0, 0, 0));
        send_event(make_event(FUNC_POSITION, 0, 0, 0, 0, 0));
        send_event(make_event(FUNC_TICK, 0, 0, 0, 0, 0));
        ev = make_event(FUNC_HEADING, 0, 0, 0, 0, 0);
        ev.heading_fix = 16'sd17999;
        send_event(ev);
        send_event(make_event(FUNC_TICK, 0, 0, 0, 0, 0));
        send_event(make_event(FUNC_POSITION, 24'sh7F_FFFF, 24'sh7F_FFFF, 0, 0, 0));
        send_event(make_event(FUNC_GOAL, 24'sh80_0000, 24'sh80_0000, 16'hFFFF, 2'd3, 0));
        send_event(make_event(FUNC_TICK, 0, 0, 0, 0, 0));
        send_event(make_event(FUNC_POSITION, 24'sh7F_FFFF, 24'sh80_0000, 0, 0, 0));
        send_event(make_event(FUNC_TICK, 0, 0, 0, 0, 0));
        send_event(make_event(FUNC_GOAL, 10, -5, 16'd7, KIND_PARKING, 32'hFFFF_FFF0));
        send_event(make_event(FUNC_POSITION, 0, 0, 0, 0, 0));
        send_event(make_event(FUNC_TICK, 0, 0, 0, 0, 32'h0000_0010));
        send_event(make_event(FUNC_TICK, 0, 0, 0, 0, 32'h8000_0000));
        send_event(make_event(FUNC_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF));
        send_event(make_event(FUNC_GOAL, 10, -5, 16'd7, 2'd2, 32'd1));
        send_event(make_event(FUNC_GOAL, 10, -5, 16'd7, KIND_PARKING, 32'd1));
        send_event(make_event(FUNC_TICK, 0, 0, 0, 0, 32'h7FFF_FFFF));
        send_event(make_event(FUNC_POSITION, -24'sd5000, 0, 0, 0, 0));
        send_event(make_event(FUNC_TICK, 0, 0, 0, 0, 32'd3));
        // Sender holds off until everything queued so far has come back.
        drain_reports();

        clock_ms = 0;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            // Registers change only while the block is idle.
            case (phase)
                0: begin write_reg(REG_CAPTURE, 32'hFF_FFFF); write_reg(REG_SLIP, 0); end
                1: write_reg(REG_PASSTHROUGH, 1);
                2: begin write_reg(REG_CAPTURE, 0); write_reg(REG_SLIP, 32'hFF_FFFF); end
                3: write_reg(REG_PASSTHROUGH, 0);
                default:
                begin
                    write_reg(REG_CAPTURE, $urandom_range(3000));
                    write_reg(REG_SLIP, $urandom_range(3000));
                    write_reg(REG_PASSTHROUGH, $urandom_range(1));
                end
            endcase
            repeat (94)
                send_event(rand_event(clock_ms));
            drain_reports();
        end

        $display("Covered %0d events, %0d reports checked (%0d parking ticks), eight phases.",
            events_sent, board.reports_checked, ticks_parking);
        if (board.mismatches == 0 && board.pending_reports.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- waypoint_bearing_and_capture_top.f -----
rtl/core/wbc_pkg.sv
rtl/core/wbc_magnitude.sv
rtl/core/wbc_bearing.sv
rtl/core/waypoint_bearing_and_capture_top.sv
sim/tb_waypoint_bearing_and_capture_top.sv
